// ===== src/ctok_pkg.sv =====
// Shared types and constants of the source tokenizer.
`timescale 1ns / 1ps

package ctok_pkg;

   // Longest token length that is counted before the length saturates.
   localparam int LEXEME_LIMIT = 255;
   localparam logic [7:0] LEN_CAP = 8'((LEXEME_LIMIT < 255) ? LEXEME_LIMIT : 255);

   // Result queue geometry.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Token kinds as they appear on the result channel.
   typedef enum logic [2:0] {
      KIND_KEYWORD  = 3'd0,
      KIND_CONSTANT = 3'd1,
      KIND_IDENT    = 3'd2,
      KIND_OPERATOR = 3'd3,
      KIND_SPECIAL  = 3'd4,
      KIND_UNKNOWN  = 3'd5
   } kind_type;

   // Keyword table, each word packed right-aligned with its first byte highest.
   localparam int KW_COUNT = 20;
   localparam logic [63:0] KW_WORDS [KW_COUNT] = '{
      64'("int"), 64'("float"), 64'("return"), 64'("if"), 64'("else"),
      64'("while"), 64'("for"), 64'("do"), 64'("break"), 64'("continue"),
      64'("char"), 64'("double"), 64'("void"), 64'("switch"), 64'("case"),
      64'("default"), 64'("const"), 64'("static"), 64'("sizeof"), 64'("struct")
   };
   localparam logic [7:0] KW_LENS [KW_COUNT] = '{
      8'd3, 8'd5, 8'd6, 8'd2, 8'd4, 8'd5, 8'd3, 8'd2, 8'd5, 8'd8,
      8'd4, 8'd6, 8'd4, 8'd6, 8'd4, 8'd7, 8'd5, 8'd6, 8'd6, 8'd6
   };

   // One result transaction.
   typedef struct packed {
      kind_type    kind;
      logic [4:0]  keyword_index;
      logic [31:0] start;
      logic [7:0]  length;
      logic        end_marker;
      logic        last_result;
   } result_type;

   // Results produced by the scanner for one input byte, in order.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ===== src/ctok_if.sv =====
// Valid/ready channel interfaces for source bytes and tokens.
`timescale 1ns / 1ps

interface ctok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface ctok_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [4:0]  keyword_index;
   logic [31:0] token_start;
   logic [7:0]  token_length;
   logic        end_marker;
   logic        last_result;

   modport source (output valid, output token_kind, output keyword_index,
                   output token_start, output token_length, output end_marker,
                   output last_result, input ready);
   modport sink (input valid, input token_kind, input keyword_index,
                 input token_start, input token_length, input end_marker,
                 input last_result, output ready);
endinterface

// ===== src/c_source_tokenizer.sv =====
// Path: a byte's tokens pass from the input register through the result queue.
// Throughput: one byte per cycle; a byte that closes one token and forms another
// yields two results that leave in order through a four-entry result queue,
// and input stalls while that queue holds more than two results.
// Reset: synchronous; the scanner goes idle, offsets restart at 0, the queue empties.
`timescale 1ns / 1ps

module c_source_tokenizer
   import ctok_pkg::*;
#(
   parameter int OFFSET_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   ctok_req_if.sink   req_bus,
   ctok_rsp_if.source rsp_bus
);

   push_type push;
   logic     room;

   // Byte scanner with its input register.
   ctok_scan #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .room    (room),
      .push    (push)
   );

   // Result queue feeding the result channel.
   ctok_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .room    (room),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== src/ctok_scan.sv =====
// Input register and per-byte scan state of the tokenizer.
`timescale 1ns / 1ps

module ctok_scan
   import ctok_pkg::*;
#(
   parameter int OFFSET_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   ctok_req_if.sink     req_bus,
   input  logic         room,
   output push_type     push
);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_STRING,
      MODE_CHAR1,
      MODE_CHAR2
   } mode_type;

   // Byte classes.
   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic kind_type single_kind(input logic [7:0] b);
      kind_type k;
      case (b)
         "+", "-", "*", "/", "%", "=", "!", "<", ">", "|", "&": k = KIND_OPERATOR;
         ",", ";", "{", "}", "(", ")", "[", "]":                k = KIND_SPECIAL;
         default:                                               k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_byte_ff, in_byte_in;
   logic                    in_eoi_ff, in_eoi_in;
   mode_type                mode_ff, mode_in;
   logic [OFFSET_WIDTH-1:0] pstart_ff, pstart_in;
   logic [7:0]              plen_ff, plen_in;
   logic                    dot_ff, dot_in;
   logic                    ewd_ff, ewd_in;
   logic [63:0]             win_ff, win_in;
   logic [OFFSET_WIDTH-1:0] off_ff, off_in;

   logic       advance;
   logic [7:0] b;
   logic [7:0] plen_inc;
   logic       kw_hit;
   logic [4:0] kw_index;
   kind_type   pend_kind;
   logic       emit_a, emit_b, again;
   result_type res_a, res_b;

   // The input register takes a new transaction whenever it is empty or its content moves on.
   assign advance         = in_valid_ff && room;
   assign req_bus.ready   = !in_valid_ff || advance;
   assign b               = in_byte_ff;
   assign plen_inc        = (plen_ff < LEN_CAP) ? plen_ff + 8'd1 : plen_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_eoi_in   = in_eoi_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
         in_byte_in  = req_bus.in_byte;
         in_eoi_in   = req_bus.end_of_input;
      end
   end

   // Keyword match over the last eight bytes of the pending word.
   always_comb begin
      kw_hit   = 1'b0;
      kw_index = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (!kw_hit && plen_ff == KW_LENS[k] && win_ff == KW_WORDS[k]) begin
            kw_hit   = 1'b1;
            kw_index = 5'(k);
         end
      end
   end

   // Kind of the pending token if it were closed now.
   always_comb begin
      case (mode_ff)
         MODE_IDENT:  pend_kind = kw_hit ? KIND_KEYWORD : KIND_IDENT;
         MODE_NUMBER: pend_kind = ewd_ff ? KIND_UNKNOWN : KIND_CONSTANT;
         default:     pend_kind = KIND_UNKNOWN;
      endcase
   end

   // Next scan state and the results of the byte in the input register.
   always_comb begin
      mode_in   = mode_ff;
      pstart_in = pstart_ff;
      plen_in   = plen_ff;
      dot_in    = dot_ff;
      ewd_in    = ewd_ff;
      win_in    = win_ff;
      off_in    = off_ff;
      emit_a    = 1'b0;
      emit_b    = 1'b0;
      again     = 1'b0;

      res_a.kind          = pend_kind;
      res_a.keyword_index = (mode_ff == MODE_IDENT && kw_hit) ? kw_index : 5'd0;
      res_a.start         = 32'(pstart_ff);
      res_a.length        = plen_ff;
      res_a.end_marker    = 1'b0;
      res_a.last_result   = 1'b0;

      res_b.kind          = single_kind(b);
      res_b.keyword_index = 5'd0;
      res_b.start         = 32'(off_ff);
      res_b.length        = 8'd1;
      res_b.end_marker    = 1'b0;
      res_b.last_result   = 1'b1;

      if (in_eoi_ff) begin
         // End of source: flush, then the end marker, then back to reset state.
         emit_a           = (mode_ff != MODE_IDLE);
         emit_b           = 1'b1;
         res_b.kind       = KIND_UNKNOWN;
         res_b.length     = 8'd0;
         res_b.end_marker = 1'b1;
         mode_in          = MODE_IDLE;
         pstart_in        = '0;
         plen_in          = '0;
         dot_in           = 1'b0;
         ewd_in           = 1'b0;
         win_in           = '0;
         off_in           = '0;
      end else begin
         unique case (mode_ff)
            MODE_IDENT: begin
               if (is_alpha(b) || is_digit(b) || b == "_") begin
                  plen_in = plen_inc;
                  win_in  = {win_ff[55:0], b};
               end else begin
                  emit_a = 1'b1;
                  again  = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit(b)) begin
                  plen_in = plen_inc;
                  win_in  = {win_ff[55:0], b};
                  ewd_in  = 1'b0;
               end else if (b == "." && !dot_ff) begin
                  plen_in = plen_inc;
                  win_in  = {win_ff[55:0], b};
                  dot_in  = 1'b1;
                  ewd_in  = 1'b1;
               end else begin
                  emit_a = 1'b1;
                  again  = 1'b1;
               end
            end
            MODE_STRING: begin
               plen_in = plen_inc;
               win_in  = {win_ff[55:0], b};
               if (b == "\"") begin
                  emit_a       = 1'b1;
                  res_a.kind   = KIND_CONSTANT;
                  res_a.length = plen_inc;
                  mode_in      = MODE_IDLE;
               end
            end
            MODE_CHAR1: begin
               plen_in = plen_inc;
               win_in  = {win_ff[55:0], b};
               mode_in = MODE_CHAR2;
            end
            MODE_CHAR2: begin
               emit_a = 1'b1;
               if (b == "'") begin
                  plen_in      = plen_inc;
                  win_in       = {win_ff[55:0], b};
                  res_a.kind   = KIND_CONSTANT;
                  res_a.length = plen_inc;
                  mode_in      = MODE_IDLE;
               end else begin
                  again = 1'b1;
               end
            end
            default: begin
               again = 1'b1;
            end
         endcase

         // A byte that ends a token without belonging to it, or arrives between tokens, starts afresh.
         if (again) begin
            mode_in = MODE_IDLE;
            if (is_space(b)) begin
               mode_in = MODE_IDLE;
            end else if (is_alpha(b) || b == "_" || is_digit(b) || b == "\"" || b == "'") begin
               if (is_digit(b)) begin
                  mode_in = MODE_NUMBER;
               end else if (b == "\"") begin
                  mode_in = MODE_STRING;
               end else if (b == "'") begin
                  mode_in = MODE_CHAR1;
               end else begin
                  mode_in = MODE_IDENT;
               end
               pstart_in = off_ff;
               plen_in   = 8'd1;
               dot_in    = 1'b0;
               ewd_in    = 1'b0;
               win_in    = {56'd0, b};
            end else begin
               emit_b = 1'b1;
            end
         end
         off_in = off_ff + OFFSET_WIDTH'(1);
      end
   end

   // Order the results; the final one carries last_result.
   always_comb begin
      push.count  = 2'd0;
      push.first  = res_a;
      push.second = res_b;
      if (advance) begin
         if (emit_a && emit_b) begin
            push.count = 2'd2;
         end else if (emit_a) begin
            push.count             = 2'd1;
            push.first.last_result = 1'b1;
         end else if (emit_b) begin
            push.count = 2'd1;
            push.first = res_b;
         end
      end
   end

   // Input register and scan state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         pstart_ff   <= '0;
         plen_ff     <= '0;
         dot_ff      <= 1'b0;
         ewd_ff      <= 1'b0;
         win_ff      <= '0;
         off_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            mode_ff   <= mode_in;
            pstart_ff <= pstart_in;
            plen_ff   <= plen_in;
            dot_ff    <= dot_in;
            ewd_ff    <= ewd_in;
            win_ff    <= win_in;
            off_ff    <= off_in;
         end
      end
      in_byte_ff <= in_byte_in;
      in_eoi_ff  <= in_eoi_in;
   end

   // The end of a source always returns the scanner to its reset state.
   assert property (@(posedge clock) disable iff (reset)
      advance && in_eoi_ff |=> mode_ff == MODE_IDLE && off_ff == '0 && plen_ff == '0)
      else $error("scanner state not cleared after end of source");

   // The pending length never passes its saturation value.
   assert property (@(posedge clock) disable iff (reset) plen_ff <= LEN_CAP)
      else $error("pending length above cap");

   // An end of source transaction always ends in an end marker.
   assert property (@(posedge clock) disable iff (reset)
      advance && in_eoi_ff |->
         (push.count == 2'd2 && push.second.end_marker) ||
         (push.count == 2'd1 && push.first.end_marker))
      else $error("end of source without end marker");

endmodule

// ===== src/ctok_queue.sv =====
// Small result queue that decouples the scanner from the result channel.
`timescale 1ns / 1ps

module ctok_queue
   import ctok_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,
   ctok_rsp_if.source rsp_bus
);

   result_type             mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] head_ff, head_in;
   logic [QUEUE_PTR_W-1:0] tail_ff, tail_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   pop;
   result_type             out_item;

   // Room for the two results one byte can cause.
   assign room = count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
   assign pop  = rsp_bus.valid && rsp_bus.ready;

   // Head of the queue drives the result channel.
   assign out_item              = mem[head_ff];
   assign rsp_bus.valid         = count_ff != '0;
   assign rsp_bus.token_kind    = out_item.kind;
   assign rsp_bus.keyword_index = out_item.keyword_index;
   assign rsp_bus.token_start   = out_item.start;
   assign rsp_bus.token_length  = out_item.length;
   assign rsp_bus.end_marker    = out_item.end_marker;
   assign rsp_bus.last_result   = out_item.last_result;

   assign head_in  = pop ? head_ff + QUEUE_PTR_W'(1) : head_ff;
   assign tail_in  = tail_ff + QUEUE_PTR_W'(push.count);
   assign count_in = count_ff + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Storage: up to two results written per cycle.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[tail_ff + QUEUE_PTR_W'(1)] <= push.second;
      end
   end

   // The fill count never passes the depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   // The scanner only pushes when it was told there is room.
   assert property (@(posedge clock) disable iff (reset) push.count != 2'd0 |-> room)
      else $error("push into full result queue");

   // The fill count holds still when there is neither a push nor a pop.
   assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd0 && !pop |=> $stable(count_ff))
      else $error("fill count changed without traffic");

endmodule
